### rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV conversion package
// Port widths, divider step count and hue sector codes.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int CH_W      = 16;
    localparam int HUE_W     = 16;
    localparam int SAT_W     = 13;
    localparam int VAL_W     = 13;
    localparam int HUE_STEPS = 16;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

endpackage

### rtl/rgb_to_hsv_convert_core.sv
// ----------------------------------------------------------------------------
// RGB to HSV conversion core
// Pipeline: clamp, min/max, sector numerator, then 16 restoring divider
// stages for hue, of which the first FRAC_BITS also step saturation.
// Throughput: one pixel per cycle; the pipeline holds as a whole while the
// result is stalled. The divider stage chain sets the latency.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_core #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pix_valid,
    output logic                                 pix_stall,
    input  logic signed [rgbhsv_pkg::CH_W-1:0]   red_in,
    input  logic signed [rgbhsv_pkg::CH_W-1:0]   green_in,
    input  logic signed [rgbhsv_pkg::CH_W-1:0]   blue_in,
    output logic                                 hsv_valid,
    input  logic                                 hsv_stall,
    output logic        [rgbhsv_pkg::HUE_W-1:0]  hue_out,
    output logic        [rgbhsv_pkg::SAT_W-1:0]  sat_out,
    output logic        [rgbhsv_pkg::VAL_W-1:0]  val_out
);
    import rgbhsv_pkg::*;

    localparam int CW = FRAC_BITS + 1;
    localparam int DW = FRAC_BITS + 3;
    localparam int QW = FRAC_BITS + 1;
    localparam int NS = HUE_STEPS;
    localparam logic [CW-1:0] ONE_VAL = CW'(1) << FRAC_BITS;

    function automatic logic [CW-1:0] clamp_ch(input logic signed [CH_W-1:0] x);
        logic signed [CH_W+1:0] xe;
        logic signed [CH_W+1:0] one_e;
        logic        [CW-1:0]   res;
        xe    = (CH_W+2)'(x);
        one_e = $signed((CH_W+2)'(ONE_VAL));
        if (x[CH_W-1])
        begin
            res = '0;
        end
        else if (xe > one_e)
        begin
            res = ONE_VAL;
        end
        else
        begin
            res = CW'(x[CH_W-2:0]);
        end
        return res;
    endfunction

    logic adv;
    logic [NS+2:0] valid_reg;

    assign adv       = !(valid_reg[NS+2] && hsv_stall);
    assign pix_stall = !adv;
    assign hsv_valid = valid_reg[NS+2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NS+1:0], pix_valid};
        end
    end

    // Stage 1: clamp
    logic [CW-1:0] r1_reg, g1_reg, b1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg <= clamp_ch(red_in);
            g1_reg <= clamp_ch(green_in);
            b1_reg <= clamp_ch(blue_in);
        end
    end

    // Stage 2: max, min, chroma, sector difference
    logic                 red_sel, grn_sel;
    logic                 rmin, gmin;
    logic [CW-1:0]        vmax_next, vmin_next;
    logic signed [CW:0]   diff_next;
    sector_t              sec_next;
    logic [CW-1:0]        vmax2_reg, chroma2_reg;
    logic signed [CW:0]   diff2_reg;
    sector_t              sec2_reg;

    always_comb
    begin
        red_sel = (r1_reg >= g1_reg) && (r1_reg >= b1_reg);
        grn_sel = !red_sel && (g1_reg >= b1_reg);
        rmin    = (r1_reg <= g1_reg) && (r1_reg <= b1_reg);
        gmin    = !rmin && (g1_reg <= b1_reg);
        if (red_sel)
        begin
            vmax_next = r1_reg;
            sec_next  = SEC_RED;
            diff_next = $signed({1'b0, g1_reg}) - $signed({1'b0, b1_reg});
        end
        else if (grn_sel)
        begin
            vmax_next = g1_reg;
            sec_next  = SEC_GREEN;
            diff_next = $signed({1'b0, b1_reg}) - $signed({1'b0, r1_reg});
        end
        else
        begin
            vmax_next = b1_reg;
            sec_next  = SEC_BLUE;
            diff_next = $signed({1'b0, r1_reg}) - $signed({1'b0, g1_reg});
        end
        if (rmin)
        begin
            vmin_next = r1_reg;
        end
        else if (gmin)
        begin
            vmin_next = g1_reg;
        end
        else
        begin
            vmin_next = b1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vmax2_reg   <= vmax_next;
            chroma2_reg <= vmax_next - vmin_next;
            diff2_reg   <= diff_next;
            sec2_reg    <= sec_next;
        end
    end

    // Stage 3: hue numerator, divisors, saturation integer bit
    logic [DW-1:0]        chroma_e;
    logic [DW-1:0]        hd_next;
    logic signed [DW:0]   diff_e;
    logic signed [DW:0]   num_next;
    logic                 sint_next;

    logic [DW-1:0]  hrem_reg [0:NS];
    logic [DW-1:0]  hd_reg   [0:NS];
    logic [HUE_W-1:0] hq_reg [0:NS];
    logic [CW-1:0]  srem_reg [0:NS];
    logic [QW-1:0]  sq_reg   [0:NS];
    logic [CW-1:0]  vmax_reg [0:NS];
    logic           gray_reg [0:NS];

    always_comb
    begin
        chroma_e  = DW'(chroma2_reg);
        hd_next   = (chroma_e << 2) + (chroma_e << 1);
        diff_e    = (DW+1)'(diff2_reg);
        sint_next = (chroma2_reg == vmax2_reg);
        case (sec2_reg)
            SEC_RED:
            begin
                if (diff2_reg < 0)
                begin
                    num_next = diff_e + $signed({1'b0, hd_next});
                end
                else
                begin
                    num_next = diff_e;
                end
            end
            SEC_GREEN:
            begin
                num_next = diff_e + $signed({1'b0, chroma_e << 1});
            end
            default:
            begin
                num_next = diff_e + $signed({1'b0, chroma_e << 2});
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hrem_reg[0] <= DW'(num_next);
            hd_reg[0]   <= hd_next;
            hq_reg[0]   <= '0;
            srem_reg[0] <= sint_next ? '0 : chroma2_reg;
            sq_reg[0]   <= QW'(sint_next);
            vmax_reg[0] <= vmax2_reg;
            gray_reg[0] <= (chroma2_reg == '0);
        end
    end

    // Stages 4 and on: one hue quotient bit per stage; saturation only in the first FRAC_BITS
    for (genvar k = 0; k < NS; k++)
    begin : g_div
        logic [DW:0]      ht;
        logic             hge;
        logic [DW-1:0]    hrem_next;
        logic [HUE_W-1:0] hq_next;
        logic [CW-1:0]    srem_next;
        logic [QW-1:0]    sq_next;

        always_comb
        begin
            ht        = {hrem_reg[k], 1'b0};
            hge       = (ht >= {1'b0, hd_reg[k]});
            hrem_next = hge ? DW'(ht - {1'b0, hd_reg[k]}) : DW'(ht);
            hq_next   = {hq_reg[k][HUE_W-2:0], hge};
        end

        if (k < FRAC_BITS)
        begin : g_sat
            logic [CW:0] st;
            logic        sge;

            always_comb
            begin
                st        = {srem_reg[k], 1'b0};
                sge       = (st >= {1'b0, vmax_reg[k]});
                srem_next = sge ? CW'(st - {1'b0, vmax_reg[k]}) : CW'(st);
                sq_next   = {sq_reg[k][QW-2:0], sge};
            end
        end
        else
        begin : g_hold
            assign srem_next = srem_reg[k];
            assign sq_next   = sq_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                hrem_reg[k+1] <= hrem_next;
                hd_reg[k+1]   <= hd_reg[k];
                hq_reg[k+1]   <= hq_next;
                srem_reg[k+1] <= srem_next;
                sq_reg[k+1]   <= sq_next;
                vmax_reg[k+1] <= vmax_reg[k];
                gray_reg[k+1] <= gray_reg[k];
            end
        end
    end

    assign hue_out = gray_reg[NS] ? '0 : hq_reg[NS];
    assign sat_out = gray_reg[NS] ? '0 : SAT_W'(sq_reg[NS]);
    assign val_out = VAL_W'(vmax_reg[NS]);

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// RGB to HSV conversion core testbench
// Drives pixels through the valid/stall input channel with random gaps,
// stalls the result channel at random, and compares every HSV result against
// an in-bench predictor that clamps the channels, picks the hue sector and
// does the two integer divisions. Directed tests cover clamping, black, grey,
// every hue sector and channel ties; a random test follows.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbhsv_pkg::*;

    localparam int     FRAC_BITS    = 12;
    localparam longint ONE_VAL      = longint'(1) << FRAC_BITS;
    localparam longint HUE_TURN     = 65536;
    localparam int     IDLE_LIMIT   = 4000;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     MAX_REPORTS  = 10;

    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] val;
    } hsv_t;

    logic                    clk;
    logic                    rst_n;
    logic                    pix_valid;
    logic                    pix_stall;
    logic signed [CH_W-1:0]  red_in;
    logic signed [CH_W-1:0]  green_in;
    logic signed [CH_W-1:0]  blue_in;
    logic                    hsv_valid;
    logic                    hsv_stall;
    logic        [HUE_W-1:0] hue_out;
    logic        [SAT_W-1:0] sat_out;
    logic        [VAL_W-1:0] val_out;

    hsv_t hsv_expected[$];
    int   err_count  = 0;
    int   idle_cycles = 0;
    bit   idle_on    = 1'b1;

    rgb_to_hsv_convert_core #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .hsv_valid(hsv_valid),
        .hsv_stall(hsv_stall),
        .hue_out  (hue_out),
        .sat_out  (sat_out),
        .val_out  (val_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint clamp_channel(input logic signed [CH_W-1:0] v);
        longint x;
        x = v;
        if (x < 0)
        begin
            x = 0;
        end
        else if (x > ONE_VAL)
        begin
            x = ONE_VAL;
        end
        return x;
    endfunction

    function automatic hsv_t predict_hsv(input logic signed [CH_W-1:0] r_in,
                                         input logic signed [CH_W-1:0] g_in,
                                         input logic signed [CH_W-1:0] b_in);
        longint  r;
        longint  g;
        longint  b;
        longint  vmax;
        longint  vmin;
        longint  chroma;
        longint  num;
        longint  quo;
        sector_t sec;
        hsv_t    res;
        r      = clamp_channel(r_in);
        g      = clamp_channel(g_in);
        b      = clamp_channel(b_in);
        vmax   = (r > g) ? r : g;
        vmax   = (vmax > b) ? vmax : b;
        vmin   = (r < g) ? r : g;
        vmin   = (vmin < b) ? vmin : b;
        chroma = vmax - vmin;
        res.hue = '0;
        res.sat = '0;
        res.val = vmax[VAL_W-1:0];
        if (vmax != 0 && chroma != 0)
        begin
            quo     = (chroma * ONE_VAL) / vmax;
            res.sat = quo[SAT_W-1:0];
            if (r == vmax)
            begin
                sec = SEC_RED;
            end
            else if (g == vmax)
            begin
                sec = SEC_GREEN;
            end
            else
            begin
                sec = SEC_BLUE;
            end
            case (sec)
                SEC_RED:
                begin
                    num = g - b;
                    if (num < 0)
                    begin
                        num = num + 6 * chroma;
                    end
                end
                SEC_GREEN: num = 2 * chroma + (b - r);
                default:   num = 4 * chroma + (r - g);
            endcase
            quo     = (num * HUE_TURN) / (6 * chroma);
            res.hue = quo[HUE_W-1:0];
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
        begin
            return 0;
        end
        else if (p < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (p < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_pixel(input logic signed [CH_W-1:0] r,
                              input logic signed [CH_W-1:0] g,
                              input logic signed [CH_W-1:0] b);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            pix_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        red_in    = r;
        green_in  = g;
        blue_in   = b;
        pix_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pix_stall);
        hsv_expected.push_back(predict_hsv(r, g, b));
        @(negedge clk);
    endtask

    // hold the result channel off in random bursts
    initial
    begin : result_stall
        int stall_left;
        stall_left = 0;
        hsv_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                hsv_stall  = 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                hsv_stall = 1'b0;
                if (idle_on && $urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        hsv_t exp_hsv;
        if (rst_n && hsv_valid && !hsv_stall)
        begin
            if (hsv_expected.size() == 0)
            begin
                err_count = err_count + 1;
                if (err_count <= MAX_REPORTS)
                begin
                    $display("ERROR: result with no pixel pending: hue=%0d sat=%0d val=%0d",
                             hue_out, sat_out, val_out);
                end
            end
            else
            begin
                exp_hsv = hsv_expected.pop_front();
                if (hue_out !== exp_hsv.hue || sat_out !== exp_hsv.sat
                    || val_out !== exp_hsv.val)
                begin
                    err_count = err_count + 1;
                    if (err_count <= MAX_REPORTS)
                    begin
                        $display("ERROR: expected hue=%0d sat=%0d val=%0d, got hue=%0d sat=%0d val=%0d",
                                 exp_hsv.hue, exp_hsv.sat, exp_hsv.val,
                                 hue_out, sat_out, val_out);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && !pix_stall) || (hsv_valid && !hsv_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic test_clamp_extremes();
        idle_on = 1'b1;
        send_pixel(-16'sd32768, -16'sd32768, -16'sd32768);
        send_pixel(16'sd32767, 16'sd32767, 16'sd32767);
        send_pixel(16'sd0, 16'sd0, 16'sd0);
        send_pixel(16'sd4096, 16'sd4096, 16'sd4096);
        send_pixel(16'sd4097, -16'sd1, 16'sd2048);
        send_pixel(16'sd32767, -16'sd32768, 16'sd0);
        send_pixel(16'sh5555, 16'shAAAA, 16'sh0FFF);
        send_pixel(16'shAAAA, 16'sh5555, 16'sh1000);
    endtask

    task automatic test_hue_sectors();
        idle_on = 1'b0;
        send_pixel(16'sd4096, 16'sd0, 16'sd0);
        send_pixel(16'sd0, 16'sd4096, 16'sd0);
        send_pixel(16'sd0, 16'sd0, 16'sd4096);
        send_pixel(16'sd4096, 16'sd4096, 16'sd0);
        send_pixel(16'sd0, 16'sd4096, 16'sd4096);
        send_pixel(16'sd4096, 16'sd0, 16'sd4096);
        send_pixel(16'sd4096, 16'sd0, 16'sd100);
        send_pixel(16'sd1, 16'sd0, 16'sd0);
        send_pixel(16'sd4096, 16'sd4095, 16'sd4096);
        send_pixel(16'sd1000, 16'sd3000, 16'sd2000);
        send_pixel(16'sd1000, 16'sd2000, 16'sd3000);
        send_pixel(16'sd7, 16'sd7, 16'sd7);
    endtask

    function automatic logic signed [CH_W-1:0] edge_channel();
        int p;
        p = $urandom_range(0, 5);
        case (p)
            0:       return CH_W'(0);
            1:       return CH_W'(ONE_VAL);
            2:       return CH_W'(-1);
            3:       return CH_W'(ONE_VAL + 1);
            4:       return CH_W'($urandom_range(0, 3));
            default: return CH_W'(ONE_VAL - $urandom_range(0, 3));
        endcase
    endfunction

    task automatic test_random_pixels(input int count);
        logic signed [CH_W-1:0] r;
        logic signed [CH_W-1:0] g;
        logic signed [CH_W-1:0] b;
        int                     p;
        for (int i = 0; i < count; i++)
        begin
            idle_on = ((i / 50) % 4) != 3;
            p = $urandom_range(0, 99);
            if (p < 60)
            begin
                r = CH_W'($urandom_range(0, ONE_VAL));
                g = CH_W'($urandom_range(0, ONE_VAL));
                b = CH_W'($urandom_range(0, ONE_VAL));
            end
            else if (p < 75)
            begin
                r = CH_W'($urandom);
                g = CH_W'($urandom);
                b = CH_W'($urandom);
            end
            else if (p < 90)
            begin
                r = CH_W'($urandom_range(0, ONE_VAL));
                g = $urandom_range(0, 1) ? r : CH_W'($urandom_range(0, ONE_VAL));
                b = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? r : g)
                                         : CH_W'($urandom_range(0, ONE_VAL));
            end
            else
            begin
                r = edge_channel();
                g = edge_channel();
                b = edge_channel();
            end
            send_pixel(r, g, b);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        pix_valid = 1'b0;
        red_in    = '0;
        green_in  = '0;
        blue_in   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_clamp_extremes();
        test_hue_sectors();
        test_random_pixels(400);

        pix_valid = 1'b0;
        idle_on   = 1'b1;
        while (hsv_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && hsv_expected.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
